// ===== rtl/core/cdts_pkg.sv =====
package cdts_pkg;

    localparam int ID_W     = 6;
    localparam int ID_SLOTS = 64;
    localparam int CNT_W    = 32;
    localparam int LIM_W    = 8;

    // func codes
    localparam logic [1:0] FUNC_HDR   = 2'd0;
    localparam logic [1:0] FUNC_CHILD = 2'd1;
    localparam logic [1:0] FUNC_STEP  = 2'd2;

    // node kinds
    localparam logic [2:0] KIND_NODE    = 3'd0;
    localparam logic [2:0] KIND_MODUL   = 3'd1;
    localparam logic [2:0] KIND_ROOT    = 3'd2;
    localparam logic [2:0] KIND_CONN    = 3'd3;
    localparam logic [2:0] KIND_MODROOT = 3'd4;

    // event kinds
    localparam logic [1:0] EV_ON   = 2'd0;
    localparam logic [1:0] EV_OFF  = 2'd1;
    localparam logic [1:0] EV_FILL = 2'd2;
    localparam logic [1:0] EV_MOD  = 2'd3;

    // config register indexes
    localparam logic [1:0] CFG_ROOT     = 2'd0;
    localparam logic [1:0] CFG_LOOP_EN  = 2'd1;
    localparam logic [1:0] CFG_LOOP_LIM = 2'd2;

    typedef struct packed {
        logic [1:0]       func;
        logic [ID_W-1:0]  node_id;
        logic [2:0]       node_kind;
        logic [LIM_W-1:0] count_limit;
        logic [3:0]       child_total;
        logic [2:0]       child_slot;
        logic [ID_W-1:0]  child_id;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_qhead;

    typedef struct packed {
        logic [1:0]       kind;
        logic [ID_W-1:0]  node;
        logic [LIM_W-1:0] fill;
        logic [LIM_W-1:0] lim;
    } t_ev;

    typedef struct packed {
        logic            v;
        logic            on;
        logic [ID_W-1:0] node;
    } t_light;

endpackage

// ===== rtl/core/cdts_if.sv =====
interface cdts_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [5:0] node_id;
    logic [2:0] node_kind;
    logic [7:0] count_limit;
    logic [3:0] child_total;
    logic [2:0] child_slot;
    logic [5:0] child_id;
    modport source (output valid, func, node_id, node_kind, count_limit, child_total,
                    child_slot, child_id, input ready);
    modport sink (input valid, func, node_id, node_kind, count_limit, child_total,
                  child_slot, child_id, output ready);
endinterface

interface cdts_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_kind;
    logic [5:0] event_node;
    logic [7:0] fill_value;
    logic [7:0] fill_limit;
    logic       still_running;
    logic       last_of_run;
    modport source (output valid, event_kind, event_node, fill_value, fill_limit,
                    still_running, last_of_run, input ready);
    modport sink (input valid, event_kind, event_node, fill_value, fill_limit,
                  still_running, last_of_run, output ready);
endinterface

interface cdts_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/count_divisor_tree_sequencer_unit.sv =====
// channel  | dir | handshake          | carries
// i_in     | in  | valid/ready        | func, node_id, node_kind, count_limit,
//          |     |                    | child_total, child_slot, child_id
// o_out    | out | valid/ready        | event_kind, event_node, fill_value,
//          |     |                    | fill_limit, still_running, last_of_run
// i_cfg    | in  | valid/ready (=1)   | index, data
//
// load transactions are written from the idle state; start and end steps go straight to emit
// an active step runs the remainder unit once for each present child with a nonzero limit;
// the remainder unit retires one dividend bit per cycle
// reset is synchronous: phase start, node table and visit counts read as empty
// a two-entry queue lets input transactions land while the back end works;
// the output register holds a result until taken, a stalled receiver holds the emit phase
module count_divisor_tree_sequencer_unit #(
    parameter int NODE_COUNT   = 64,
    parameter int MAX_CHILDREN = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cdts_in_if.sink     i_in,
    cdts_out_if.source  o_out,
    cdts_cfg_if.sink    i_cfg
);
    // configuration registers
    logic [cdts_pkg::ID_W-1:0] r_root;
    logic                      r_loop_en;
    logic [15:0]               r_loop_lim;

    // front to back link
    cdts_pkg::t_qhead q_head;
    logic             q_pop;

    // config port never stalls
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root     <= '0;
            r_loop_en  <= 1'b0;
            r_loop_lim <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                cdts_pkg::CFG_ROOT:     r_root     <= i_cfg.data[cdts_pkg::ID_W-1:0];
                cdts_pkg::CFG_LOOP_EN:  r_loop_en  <= i_cfg.data[0];
                cdts_pkg::CFG_LOOP_LIM: r_loop_lim <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // front: accept, drop unknown funcs, queue
    cdts_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_pop   (q_pop),
        .o_q     (q_head)
    );

    // back: table loads, the walk and result sequencing
    cdts_back #(
        .NODE_COUNT   (NODE_COUNT),
        .MAX_CHILDREN (MAX_CHILDREN)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q        (q_head),
        .o_pop      (q_pop),
        .i_root     (r_root),
        .i_loop_en  (r_loop_en),
        .i_loop_lim (r_loop_lim),
        .o_out      (o_out)
    );
endmodule

// ===== rtl/core/cdts_ram.sv =====
module cdts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/cdts_mod.sv =====
module cdts_mod (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [cdts_pkg::CNT_W-1:0]   i_dividend,
    input  logic [cdts_pkg::LIM_W-1:0]   i_divisor,
    output logic                         o_done,
    output logic [cdts_pkg::LIM_W-1:0]   o_rem
);
    logic                         r_busy;
    logic                         r_done;
    logic [4:0]                   r_cnt;
    logic [cdts_pkg::CNT_W-1:0]   r_q;
    logic [cdts_pkg::LIM_W-1:0]   r_rem;
    logic [cdts_pkg::LIM_W-1:0]   r_d;
    logic [cdts_pkg::LIM_W:0]     n_trial;
    logic [cdts_pkg::LIM_W-1:0]   n_rem;

    // one restoring step per cycle, msb first
    always_comb begin
        n_trial = {r_rem, r_q[cdts_pkg::CNT_W-1]};
        if (n_trial >= {1'b0, r_d}) begin
            n_rem = cdts_pkg::LIM_W'(n_trial - {1'b0, r_d});
        end else begin
            n_rem = n_trial[cdts_pkg::LIM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd31;
                r_q    <= i_dividend;
                r_d    <= i_divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_q   <= {r_q[cdts_pkg::CNT_W-2:0], 1'b0};
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
endmodule

// ===== rtl/core/cdts_front.sv =====
module cdts_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    cdts_in_if.sink            i_in,
    input  logic               i_pop,
    output cdts_pkg::t_qhead   o_q
);
    cdts_pkg::t_cmd r_mem [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic           keep;
    logic           push;
    logic           pop;
    cdts_pkg::t_cmd cmd;

    always_comb begin
        cmd.func        = i_in.func;
        cmd.node_id     = i_in.node_id;
        cmd.node_kind   = i_in.node_kind;
        cmd.count_limit = i_in.count_limit;
        cmd.child_total = i_in.child_total;
        cmd.child_slot  = i_in.child_slot;
        cmd.child_id    = i_in.child_id;
        // unknown func codes are taken and dropped here
        keep = i_in.func inside {cdts_pkg::FUNC_HDR, cdts_pkg::FUNC_CHILD,
                                 cdts_pkg::FUNC_STEP};
        push = i_in.valid && i_in.ready && keep;
        pop  = i_pop && (r_cnt != 2'd0);
    end

    assign i_in.ready = (r_cnt != 2'd2);
    assign o_q.valid  = (r_cnt != 2'd0);
    assign o_q.cmd    = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_mem[r_wp] <= cmd;
                r_wp        <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end
endmodule

// ===== rtl/core/cdts_back.sv =====
module cdts_back #(
    parameter int NODE_COUNT   = 64,
    parameter int MAX_CHILDREN = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  cdts_pkg::t_qhead            i_q,
    output logic                        o_pop,
    input  logic [cdts_pkg::ID_W-1:0]   i_root,
    input  logic                        i_loop_en,
    input  logic [15:0]                 i_loop_lim,
    cdts_out_if.source                  o_out
);
    localparam int CA_W = $clog2(cdts_pkg::ID_SLOTS * MAX_CHILDREN);
    localparam int SL_W = $clog2(MAX_CHILDREN + 1);
    localparam int IX_W = (MAX_CHILDREN > 1) ? $clog2(MAX_CHILDREN) : 1;

    typedef enum logic [2:0] {S_IDLE, S_RD, S_CH, S_INF, S_MOD, S_DEC, S_EMIT} t_st;
    typedef enum logic [2:0] {E_HEAD, E_FILL, E_MODS, E_T0, E_T1, E_FLUSH} t_es;
    typedef enum logic [1:0] {PH_START, PH_ACTIVE, PH_END} t_phase;

    t_st    r_st;
    t_es    r_es;
    t_phase r_phase;

    logic [cdts_pkg::ID_W-1:0]     r_cur, r_prev, r_ref, r_c;
    logic [15:0]                   r_loops;
    logic [cdts_pkg::ID_SLOTS-1:0] r_vv, r_pres;
    logic [cdts_pkg::CNT_W-1:0]    r_count;
    logic [SL_W-1:0]               r_i, r_tot;
    logic [cdts_pkg::LIM_W-1:0]    r_best, r_lim;
    logic [2:0]                    r_kind;
    logic                          r_run;
    cdts_pkg::t_light              r_t0, r_t1;

    // per-slot results of the child scan
    logic                          r_s_pres [MAX_CHILDREN];
    logic                          r_s_mod  [MAX_CHILDREN];
    logic [cdts_pkg::ID_W-1:0]     r_s_id   [MAX_CHILDREN];
    logic [cdts_pkg::LIM_W-1:0]    r_s_fill [MAX_CHILDREN];
    logic [cdts_pkg::LIM_W-1:0]    r_s_lim  [MAX_CHILDREN];

    cdts_pkg::t_ev                 r_hold, r_oev;
    logic                          r_hv, r_ov, r_olast, r_orun;

    cdts_pkg::t_cmd                cmd;
    logic                          hdr_we, ch_we, cnt_we;
    logic [CA_W-1:0]               ch_waddr, ch_raddr;
    logic [SL_W-1:0]               rd_slot, tot_sat, tot_new;
    logic [cdts_pkg::ID_W-1:0]     info_raddr, child_q;
    logic [14:0]                   info_q;
    logic [cdts_pkg::CNT_W-1:0]    visit_q, cnt_new;
    logic                          last_slot;
    logic [IX_W-1:0]               wi;
    logic [15:0]                   loops_n;
    logic                          mod_start, mod_done;
    logic [cdts_pkg::LIM_W-1:0]    mod_rem;
    cdts_pkg::t_ev                 cand;
    logic                          cand_v, can_push, adv, push_mid, push_last;

    function automatic logic f_present(input logic [cdts_pkg::ID_SLOTS-1:0] v,
                                       input logic [cdts_pkg::ID_W-1:0] id);
        return (32'(id) < NODE_COUNT) && v[id];
    endfunction

    always_comb begin
        cmd      = i_q.cmd;
        o_pop    = (r_st == S_IDLE) && i_q.valid;
        hdr_we   = o_pop && (cmd.func == cdts_pkg::FUNC_HDR)
                   && (32'(cmd.node_id) < NODE_COUNT);
        ch_we    = o_pop && (cmd.func == cdts_pkg::FUNC_CHILD)
                   && (32'(cmd.node_id) < NODE_COUNT)
                   && (32'(cmd.child_slot) < MAX_CHILDREN);
        ch_waddr = CA_W'(cmd.node_id) * CA_W'(MAX_CHILDREN) + CA_W'(cmd.child_slot);
        rd_slot  = (r_st == S_RD) ? '0 : SL_W'(r_i + 1'b1);
        ch_raddr = CA_W'(r_prev) * CA_W'(MAX_CHILDREN) + CA_W'(rd_slot);
        info_raddr = (r_st == S_CH) ? child_q : r_cur;
        cnt_new  = (r_vv[r_prev] ? visit_q : '0) + 32'd1;
        cnt_we   = (r_st == S_RD);
        tot_sat  = (32'(info_q[14:11]) > MAX_CHILDREN) ? SL_W'(MAX_CHILDREN)
                                                        : SL_W'(info_q[14:11]);
        tot_new  = f_present(r_pres, r_prev) ? tot_sat : '0;
        last_slot = (SL_W'(r_i + 1'b1) == r_tot);
        wi       = r_i[IX_W-1:0];
        loops_n  = (r_loops == 16'hFFFF) ? r_loops : r_loops + 16'd1;
        mod_start = (r_st == S_INF) && (info_q[10:3] != '0);

        // next result candidate
        cand_v = 1'b0;
        cand   = '0;
        case (r_es)
            E_HEAD: begin
                cand_v = 1'b1;
                cand   = '{cdts_pkg::EV_FILL, r_prev, 8'd0, 8'd1};
            end
            E_FILL: begin
                if (r_i != r_tot && r_s_pres[wi]) begin
                    cand_v = 1'b1;
                    cand   = '{cdts_pkg::EV_FILL, r_s_id[wi], r_s_fill[wi], r_s_lim[wi]};
                end
            end
            E_MODS: begin
                if (r_i != r_tot && r_s_mod[wi]) begin
                    cand_v = 1'b1;
                    cand   = '{cdts_pkg::EV_MOD, r_s_id[wi], 8'd0, 8'd0};
                end
            end
            E_T0: begin
                cand_v = r_t0.v && f_present(r_pres, r_t0.node);
                cand   = '{r_t0.on ? cdts_pkg::EV_ON : cdts_pkg::EV_OFF, r_t0.node,
                           8'd0, 8'd0};
            end
            E_T1: begin
                cand_v = r_t1.v && f_present(r_pres, r_t1.node);
                cand   = '{r_t1.on ? cdts_pkg::EV_ON : cdts_pkg::EV_OFF, r_t1.node,
                           8'd0, 8'd0};
            end
            default: ;
        endcase
        can_push  = !r_ov || o_out.ready;
        adv       = !cand_v || !r_hv || can_push;
        push_mid  = (r_st == S_EMIT) && (r_es != E_FLUSH) && adv && cand_v && r_hv;
        push_last = (r_st == S_EMIT) && (r_es == E_FLUSH) && r_hv && can_push;
    end

    cdts_ram #(.WIDTH(15), .DEPTH(cdts_pkg::ID_SLOTS)) u_info (
        .i_clk   (i_clk),
        .i_we    (hdr_we),
        .i_waddr (cmd.node_id),
        .i_wdata ({cmd.child_total, cmd.count_limit, cmd.node_kind}),
        .i_raddr (info_raddr),
        .o_rdata (info_q)
    );

    cdts_ram #(.WIDTH(cdts_pkg::ID_W), .DEPTH(cdts_pkg::ID_SLOTS * MAX_CHILDREN)) u_child (
        .i_clk   (i_clk),
        .i_we    (ch_we),
        .i_waddr (ch_waddr),
        .i_wdata (cmd.child_id),
        .i_raddr (ch_raddr),
        .o_rdata (child_q)
    );

    cdts_ram #(.WIDTH(cdts_pkg::CNT_W), .DEPTH(cdts_pkg::ID_SLOTS)) u_visit (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (r_prev),
        .i_wdata (cnt_new),
        .i_raddr (r_cur),
        .o_rdata (visit_q)
    );

    cdts_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (r_count),
        .i_divisor  (info_q[10:3]),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            r_es    <= E_HEAD;
            r_phase <= PH_START;
            r_cur   <= '0;
            r_prev  <= '0;
            r_ref   <= '0;
            r_loops <= '0;
            r_vv    <= '0;
            r_pres  <= '0;
            r_hv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (push_mid || push_last) begin
                r_ov    <= 1'b1;
                r_oev   <= r_hold;
                r_olast <= push_last;
                r_orun  <= r_run;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end

            case (r_st)
                S_IDLE: begin
                    if (hdr_we) begin
                        r_pres[cmd.node_id] <= 1'b1;
                    end
                    if (o_pop && cmd.func == cdts_pkg::FUNC_STEP) begin
                        case (r_phase)
                            PH_START: begin
                                r_phase <= PH_ACTIVE;
                                r_cur   <= i_root;
                                r_t0    <= '{1'b1, 1'b1, i_root};
                                r_t1    <= '0;
                                r_run   <= 1'b1;
                                r_es    <= E_T0;
                                r_st    <= S_EMIT;
                            end
                            PH_ACTIVE: begin
                                r_ref  <= r_prev;
                                r_prev <= r_cur;
                                r_st   <= S_RD;
                            end
                            PH_END: begin
                                r_t0  <= '{1'b1, 1'b0, r_ref};
                                r_t1  <= '{1'b1, 1'b0, r_cur};
                                r_run <= 1'b0;
                                r_es  <= E_T0;
                                r_st  <= S_EMIT;
                            end
                            default: ;
                        endcase
                    end
                end
                S_RD: begin
                    r_vv[r_prev] <= 1'b1;
                    r_count      <= cnt_new;
                    r_tot        <= tot_new;
                    r_best       <= '0;
                    r_i          <= '0;
                    r_st         <= (tot_new == '0) ? S_DEC : S_CH;
                end
                S_CH: begin
                    r_c <= child_q;
                    if (f_present(r_pres, child_q)) begin
                        r_st <= S_INF;
                    end else begin
                        r_s_pres[wi] <= 1'b0;
                        r_s_mod[wi]  <= 1'b0;
                        if (last_slot) begin
                            r_st <= S_DEC;
                        end else begin
                            r_i <= SL_W'(r_i + 1'b1);
                        end
                    end
                end
                S_INF: begin
                    r_lim  <= info_q[10:3];
                    r_kind <= info_q[2:0];
                    if (!mod_start) begin
                        // zero limit never divides
                        r_s_pres[wi] <= 1'b1;
                        r_s_mod[wi]  <= 1'b0;
                        r_s_id[wi]   <= r_c;
                        r_s_fill[wi] <= '0;
                        r_s_lim[wi]  <= '0;
                        if (last_slot) begin
                            r_st <= S_DEC;
                        end else begin
                            r_i  <= SL_W'(r_i + 1'b1);
                            r_st <= S_CH;
                        end
                    end else begin
                        r_st <= S_MOD;
                    end
                end
                S_MOD: begin
                    if (mod_done) begin
                        r_s_pres[wi] <= 1'b1;
                        r_s_id[wi]   <= r_c;
                        r_s_lim[wi]  <= r_lim;
                        r_s_fill[wi] <= (mod_rem == '0) ? r_lim : mod_rem;
                        r_s_mod[wi]  <= (mod_rem == '0) && (r_kind inside
                            {cdts_pkg::KIND_ROOT, cdts_pkg::KIND_CONN,
                             cdts_pkg::KIND_MODROOT});
                        if (mod_rem == '0 && r_lim > r_best && (r_kind inside
                            {cdts_pkg::KIND_NODE, cdts_pkg::KIND_MODUL})) begin
                            r_cur  <= r_c;
                            r_best <= r_lim;
                        end
                        if (last_slot) begin
                            r_st <= S_DEC;
                        end else begin
                            r_i  <= SL_W'(r_i + 1'b1);
                            r_st <= S_CH;
                        end
                    end
                end
                S_DEC: begin
                    if (r_tot != '0 && r_cur != r_prev) begin
                        r_t0  <= '{1'b1, 1'b0, r_prev};
                        r_t1  <= '{1'b1, 1'b1, r_cur};
                        r_run <= 1'b1;
                    end else if (i_loop_en) begin
                        r_loops <= loops_n;
                        r_t0    <= '{1'b1, 1'b0, r_cur};
                        if (i_loop_lim != '0 && loops_n >= i_loop_lim) begin
                            r_phase <= PH_END;
                            r_t1    <= '0;
                            r_run   <= 1'b0;
                        end else begin
                            r_t1  <= '{1'b1, 1'b1, i_root};
                            r_cur <= i_root;
                            r_run <= 1'b1;
                        end
                    end else begin
                        r_t0    <= '{1'b1, 1'b0, r_cur};
                        r_t1    <= '{1'b1, 1'b0, r_ref};
                        r_phase <= PH_END;
                        r_run   <= 1'b0;
                    end
                    r_i  <= '0;
                    r_es <= E_HEAD;
                    r_st <= S_EMIT;
                end
                S_EMIT: begin
                    if (r_es == E_FLUSH) begin
                        if (!r_hv) begin
                            r_st <= S_IDLE;
                        end else if (can_push) begin
                            r_hv <= 1'b0;
                            r_st <= S_IDLE;
                        end
                    end else if (adv) begin
                        if (cand_v) begin
                            r_hold <= cand;
                            r_hv   <= 1'b1;
                        end
                        case (r_es)
                            E_HEAD: begin
                                r_i  <= '0;
                                r_es <= E_FILL;
                            end
                            E_FILL: begin
                                if (r_i == r_tot) begin
                                    r_i  <= '0;
                                    r_es <= E_MODS;
                                end else begin
                                    r_i <= SL_W'(r_i + 1'b1);
                                end
                            end
                            E_MODS: begin
                                if (r_i == r_tot) begin
                                    r_es <= E_T0;
                                end else begin
                                    r_i <= SL_W'(r_i + 1'b1);
                                end
                            end
                            E_T0: r_es <= E_T1;
                            default: r_es <= E_FLUSH;
                        endcase
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid         = r_ov;
    assign o_out.event_kind    = r_oev.kind;
    assign o_out.event_node    = r_oev.node;
    assign o_out.fill_value    = r_oev.fill;
    assign o_out.fill_limit    = r_oev.lim;
    assign o_out.still_running = r_orun;
    assign o_out.last_of_run   = r_olast;
endmodule

// ===== rtl/core/cdts_checker.sv =====
module cdts_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_event_kind,
    input logic [5:0] i_event_node,
    input logic [7:0] i_fill_value,
    input logic [7:0] i_fill_limit
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_event_kind)
            && $stable(i_event_node) && $stable(i_fill_value))
        else $error("result changed while stalled");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_nonfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_event_kind != cdts_pkg::EV_FILL
            |-> i_fill_value == 8'd0 && i_fill_limit == 8'd0)
        else $error("fill fields set on non fill event");

    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_event_kind == cdts_pkg::EV_FILL |-> i_fill_value <= i_fill_limit)
        else $error("fill above ring size");
endmodule

bind count_divisor_tree_sequencer_unit cdts_checker u_cdts_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_event_kind (o_out.event_kind),
    .i_event_node (o_out.event_node),
    .i_fill_value (o_out.fill_value),
    .i_fill_limit (o_out.fill_limit)
);

// ===== tb/tb_count_divisor_tree_sequencer_unit.sv =====
module tb_count_divisor_tree_sequencer_unit;
    import cdts_pkg::*;

    localparam int N_ITEMS   = 310;
    localparam int MAX_CYC   = 1500000;
    localparam int HOLD_CYC  = 3000;
    localparam int SETTLE    = 400;

    // walk phases of the sequencer
    typedef enum logic [1:0] {WALK_START, WALK_ACTIVE, WALK_END} t_walk_phase;

    // one expected event transaction
    typedef struct {
        t_ev  ev;
        logic run;
        logic last;
    } t_event_exp;

    // tracks node table, walk state and the events each step must produce
    class walk_scoreboard;
        logic [5:0]  root_id;
        logic        loop_en;
        logic [15:0] loop_lim;
        t_walk_phase phase;
        logic [5:0]  cur_node, prev_node, ref_node;
        logic [15:0] loops;
        logic [31:0] visits[64];
        bit          present[64];
        logic [2:0]  kind_t[64];
        logic [7:0]  lim_t[64];
        logic [3:0]  tot_t[64];
        logic [5:0]  kids[64][8];
        t_event_exp  expq[$];
        t_ev         step_evs[$];
        int          errors;
        int          checked;
        int          steps;

        function new();
            root_id = 0; loop_en = 0; loop_lim = 0;
            phase = WALK_START;
            cur_node = 0; prev_node = 0; ref_node = 0; loops = 0;
            errors = 0; checked = 0; steps = 0;
            for (int i = 0; i < 64; i++) begin
                visits[i] = 0; present[i] = 0; kind_t[i] = 0; lim_t[i] = 0; tot_t[i] = 0;
                for (int j = 0; j < 8; j++) kids[i][j] = 0;
            end
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] v);
            case (idx)
                CFG_ROOT:     root_id  = v[5:0];
                CFG_LOOP_EN:  loop_en  = v[0];
                CFG_LOOP_LIM: loop_lim = v;
                default: ;
            endcase
        endfunction

        function int pending();
            return expq.size();
        endfunction

        function void add_ev(logic [1:0] k, logic [5:0] n, logic [7:0] f, logic [7:0] l);
            t_ev e;
            e.kind = k; e.node = n; e.fill = f; e.lim = l;
            step_evs = {step_evs, e};
        endfunction

        // highlights of absent nodes are dropped
        function void light(logic [5:0] n, bit on);
            if (present[n]) add_ev(on ? EV_ON : EV_OFF, n, 0, 0);
        endfunction

        function void note_input(t_cmd c);
            logic [5:0]  mods[$];
            int unsigned tot, best, cnt, l, fill;
            logic [5:0]  ch;
            bit          dead;
            t_event_exp  x;
            if (c.func == FUNC_HDR) begin
                present[c.node_id] = 1;
                kind_t[c.node_id]  = c.node_kind;
                lim_t[c.node_id]   = c.count_limit;
                tot_t[c.node_id]   = c.child_total;
                return;
            end
            if (c.func == FUNC_CHILD) begin
                kids[c.node_id][c.child_slot] = c.child_id;
                return;
            end
            if (c.func != FUNC_STEP) return;
            steps++;
            step_evs.delete();
            case (phase)
                WALK_START: begin
                    phase = WALK_ACTIVE;
                    cur_node = root_id;
                    light(cur_node, 1);
                end
                WALK_ACTIVE: begin
                    ref_node  = prev_node;
                    prev_node = cur_node;
                    visits[cur_node] = visits[cur_node] + 1;
                    cnt = visits[cur_node];
                    tot = 0;
                    best = 0;
                    dead = 0;
                    if (present[prev_node]) tot = (tot_t[prev_node] > 8) ? 8 : tot_t[prev_node];
                    if (tot == 0) begin
                        dead = 1;
                    end else begin
                        for (int i = 0; i < tot; i++) begin
                            ch = kids[prev_node][i];
                            l  = lim_t[ch];
                            if (!present[ch] || l == 0 || (cnt % l) != 0) continue;
                            if (kind_t[ch] <= KIND_MODUL) begin
                                if (l > best) begin
                                    cur_node = ch;
                                    best = l;
                                end
                            end else if (kind_t[ch] <= KIND_MODROOT) begin
                                mods = {mods, ch};
                            end
                        end
                        if (cur_node == prev_node) dead = 1;
                    end
                    // ring of the node just played, then its children in slot order
                    add_ev(EV_FILL, prev_node, 0, 1);
                    for (int i = 0; i < tot; i++) begin
                        ch = kids[prev_node][i];
                        if (!present[ch]) continue;
                        l = lim_t[ch];
                        if (l == 0) fill = 0;
                        else begin
                            fill = cnt % l;
                            if (fill == 0) fill = l;
                        end
                        add_ev(EV_FILL, ch, fill[7:0], l[7:0]);
                    end
                    foreach (mods[i]) add_ev(EV_MOD, mods[i], 0, 0);
                    if (!dead) begin
                        light(prev_node, 0);
                        light(cur_node, 1);
                    end else if (loop_en) begin
                        if (loops != 16'hFFFF) loops++;
                        light(cur_node, 0);
                        if (loop_lim != 0 && loops >= loop_lim) begin
                            phase = WALK_END;
                        end else begin
                            light(root_id, 1);
                            cur_node = root_id;
                        end
                    end else begin
                        light(cur_node, 0);
                        light(ref_node, 0);
                        phase = WALK_END;
                    end
                end
                WALK_END: begin
                    light(ref_node, 0);
                    light(cur_node, 0);
                end
                default: ;
            endcase
            foreach (step_evs[k]) begin
                x.ev   = step_evs[k];
                x.run  = (phase != WALK_END);
                x.last = (k == step_evs.size() - 1);
                expq = {expq, x};
            end
        endfunction

        function void check_result(t_ev ev, logic run, logic last);
            t_event_exp x;
            checked++;
            if (expq.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected event: kind %0d node %0d fill %0d lim %0d",
                             ev.kind, ev.node, ev.fill, ev.lim);
                return;
            end
            x = expq.pop_front();
            if (ev !== x.ev || run !== x.run || last !== x.last) begin
                errors++;
                if (errors <= 10)
                    $display({"event mismatch: exp k%0d n%0d f%0d l%0d r%0d e%0d,",
                              " got k%0d n%0d f%0d l%0d r%0d e%0d"},
                             x.ev.kind, x.ev.node, x.ev.fill, x.ev.lim, x.run, x.last,
                             ev.kind, ev.node, ev.fill, ev.lim, run, last);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    cdts_in_if  in_if();
    cdts_out_if out_if();
    cdts_cfg_if cfg_if();

    count_divisor_tree_sequencer_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source),
        .i_cfg   (cfg_if.sink)
    );

    walk_scoreboard sb;
    bit   gaps_on;
    bit   hold_req;
    int   cycles;
    int   items_sent;
    // which child slots have been written, so headers never expose an empty slot
    bit   slot_wr[64][8];

    initial begin
        i_clk = 0;
    end

    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYC) begin
            $display("timeout with %0d events still expected", sb.pending());
            $display("Regression FAIL");
            $finish;
        end
    end

    // result monitor, sampled on the rising edge
    always @(posedge i_clk) begin
        t_ev ev;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            ev.kind = out_if.event_kind;
            ev.node = out_if.event_node;
            ev.fill = out_if.fill_value;
            ev.lim  = out_if.fill_limit;
            sb.check_result(ev, out_if.still_running, out_if.last_of_run);
        end
    end

    // receiver: random stall bursts, one long hold-off on request
    initial begin
        out_if.ready = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                out_if.ready <= 0;
                repeat (HOLD_CYC) @(negedge i_clk);
                hold_req = 0;
                out_if.ready <= 1;
            end else if (gaps_on && $urandom_range(0, 5) == 0) begin
                out_if.ready <= 0;
                repeat ($urandom_range(1, 16) - 1) @(negedge i_clk);
            end else begin
                out_if.ready <= 1;
                repeat ($urandom_range(0, 7)) @(negedge i_clk);
            end
        end
    end

    // drive one input transaction; returns just after the accepting edge
    task automatic push_cmd(t_cmd c);
        @(negedge i_clk);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            in_if.valid <= 0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        in_if.valid       <= 1;
        in_if.func        <= c.func;
        in_if.node_id     <= c.node_id;
        in_if.node_kind   <= c.node_kind;
        in_if.count_limit <= c.count_limit;
        in_if.child_total <= c.child_total;
        in_if.child_slot  <= c.child_slot;
        in_if.child_id    <= c.child_id;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_input(c);
        if (c.func == FUNC_CHILD) slot_wr[c.node_id][c.child_slot] = 1;
        items_sent++;
    endtask

    task automatic in_idle();
        @(negedge i_clk);
        in_if.valid <= 0;
    endtask

    // wait until every expected event is out, then let trailing zero-event work finish
    task automatic drain();
        in_idle();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] v);
        @(negedge i_clk);
        cfg_if.valid <= 1;
        cfg_if.index <= idx;
        cfg_if.data  <= v;
        do @(posedge i_clk); while (!cfg_if.ready);
        sb.set_reg(idx, v);
        @(negedge i_clk);
        cfg_if.valid <= 0;
    endtask

    task automatic load_hdr(logic [5:0] id, logic [2:0] k, logic [7:0] l, logic [3:0] t);
        t_cmd c;
        c = '0;
        c.func = FUNC_HDR; c.node_id = id; c.node_kind = k; c.count_limit = l;
        c.child_total = t;
        c.child_slot = 3'($urandom); c.child_id = 6'($urandom);
        push_cmd(c);
    endtask

    task automatic load_child(logic [5:0] id, logic [2:0] s, logic [5:0] ch);
        t_cmd c;
        c = '0;
        c.func = FUNC_CHILD; c.node_id = id; c.child_slot = s; c.child_id = ch;
        c.node_kind = 3'($urandom); c.count_limit = 8'($urandom);
        push_cmd(c);
    endtask

    task automatic step_walk();
        t_cmd c;
        c = '0;
        c.func = FUNC_STEP;
        c.node_id = 6'($urandom);
        push_cmd(c);
    endtask

    function automatic logic [5:0] pick_id();
        return ($urandom_range(0, 4) != 0) ? 6'($urandom_range(0, 15)) : 6'($urandom);
    endfunction

    // random load, step or unused-func transaction; mostly steps over a dense small tree
    task automatic random_item();
        t_cmd        c;
        int unsigned r;
        int          pre;
        r = $urandom_range(0, 99);
        c = '0;
        c.node_id = pick_id();
        c.child_slot = 3'($urandom);
        c.child_id = pick_id();
        c.node_kind = ($urandom_range(0, 9) < 6) ? 3'($urandom_range(0, 1)) : 3'($urandom);
        case ($urandom_range(0, 9))
            0:       c.count_limit = 8'd0;
            1:       c.count_limit = 8'd255;
            2, 3:    c.count_limit = 8'($urandom);
            default: c.count_limit = 8'($urandom_range(1, 4));
        endcase
        if (r < 65) begin
            c.func = FUNC_STEP;
        end else if (r < 82) begin
            c.func = FUNC_CHILD;
        end else if (r < 96) begin
            c.func = FUNC_HDR;
            pre = 0;
            while (pre < 8 && slot_wr[c.node_id][pre]) pre++;
            c.child_total = (pre == 8) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, pre));
        end else begin
            c.func = 2'd3;
            c.child_total = 4'($urandom);
        end
        push_cmd(c);
    endtask

    initial begin
        sb = new();
        gaps_on = 1;
        hold_req = 0;
        items_sent = 0;
        for (int i = 0; i < 64; i++)
            for (int j = 0; j < 8; j++) slot_wr[i][j] = 0;
        in_if.valid = 0; in_if.func = 0; in_if.node_id = 0; in_if.node_kind = 0;
        in_if.count_limit = 0; in_if.child_total = 0; in_if.child_slot = 0; in_if.child_id = 0;
        cfg_if.valid = 0; cfg_if.index = 0; cfg_if.data = 0;
        i_rst_n = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1;

        write_reg(CFG_ROOT, 16'd0);
        write_reg(CFG_LOOP_EN, 16'd1);
        write_reg(CFG_LOOP_LIM, 16'd0);

        // directed: root with node, modulator, connector, modulator-root and one odd-kind
        // zero-limit child, plus a high id node
        load_child(0, 0, 1);
        load_child(0, 1, 2);
        load_child(0, 2, 3);
        load_child(0, 3, 4);
        load_child(0, 4, 5);
        load_child(0, 5, 63);
        load_hdr(0, KIND_ROOT, 8'd255, 4'd6);
        load_hdr(1, KIND_NODE, 8'd1, 4'd0);
        load_hdr(2, KIND_MODUL, 8'd2, 4'd0);
        load_hdr(3, KIND_CONN, 8'd1, 4'd0);
        load_hdr(4, KIND_MODROOT, 8'd3, 4'd0);
        load_hdr(5, 3'd7, 8'd0, 4'd0);
        load_hdr(63, KIND_NODE, 8'd4, 4'd0);
        load_child(63, 7, 63);
        begin
            t_cmd c;
            c = '1;
            c.func = 2'd3;
            push_cmd(c);
        end
        repeat (9) step_walk();

        for (int i = 0; i < N_ITEMS - 25; i++) begin
            if (i == 80) begin
                drain();
                write_reg(CFG_ROOT, 16'd63);
            end
            if (i == 120) begin
                drain();
                write_reg(CFG_ROOT, 16'd0);
                write_reg(CFG_LOOP_LIM, 16'hFFFF);
            end
            // long receiver hold-off while the input keeps offering
            if (i == 150) hold_req = 1;
            // sender waits for every outstanding event
            if (i == 200) begin
                in_idle();
                while (sb.pending() != 0) @(posedge i_clk);
            end
            if (i == 230) begin
                drain();
                write_reg(CFG_LOOP_LIM, (sb.loops > 16'hFFFD) ? 16'hFFFF : sb.loops + 16'd2);
            end
            if (i == 250) gaps_on = 0;
            random_item();
        end

        // loop off: the next dead end stops the walk, then end-phase steps
        drain();
        write_reg(CFG_LOOP_EN, 16'd0);
        write_reg(CFG_LOOP_LIM, 16'd0);
        repeat (12) step_walk();

        drain();
        $display("%0d transactions in, %0d steps, %0d events checked, %0d loops",
                 items_sent, sb.steps, sb.checked, sb.loops);
        $display("walk finished in phase %0d, %0d mismatches", sb.phase, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== count_divisor_tree_sequencer_unit.f =====
rtl/core/cdts_pkg.sv
rtl/core/cdts_if.sv
rtl/core/cdts_ram.sv
rtl/core/cdts_mod.sv
rtl/core/cdts_front.sv
rtl/core/cdts_back.sv
rtl/core/count_divisor_tree_sequencer_unit.sv
rtl/core/cdts_checker.sv
tb/tb_count_divisor_tree_sequencer_unit.sv
